/* design/elc_pkg.sv */
// Package for the three-floor elevator controller: sizes, register and floor codes,
// configuration, queue-memory and result types, and the floor decoder.
// No dependencies.
`default_nettype none

package elc_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RIDERS  = 4;
	localparam int NUM_FLOORS  = 3;

	localparam int QIDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEN_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int CIDX_W    = (MAX_RIDERS > 1) ? $clog2(MAX_RIDERS) : 1;
	localparam int CLEN_W    = $clog2(MAX_RIDERS + 1);
	localparam int ADDR_W    = QIDX_W + 2;
	localparam int MEM_DEPTH = NUM_FLOORS << QIDX_W;

	localparam logic [1:0] FLOOR_BETWEEN = 2'd3;

	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	localparam logic [1:0] REG_IDLE_TICKS = 2'd0;
	localparam logic [1:0] REG_CAPACITY   = 2'd1;
	localparam logic [1:0] REG_FLOOR1     = 2'd2;
	localparam logic [1:0] REG_FLOOR2     = 2'd3;

	localparam logic [15:0] RST_IDLE_TICKS = 16'd300;
	localparam logic [2:0]  RST_CAPACITY   = 3'd4;
	localparam logic [8:0]  RST_FLOOR1     = 9'd200;
	localparam logic [8:0]  RST_FLOOR2     = 9'd390;

	typedef struct packed {
		logic [15:0] idle_ticks;
		logic [2:0]  cabin_capacity;
		logic [8:0]  floor1_height;
		logic [8:0]  floor2_height;
	} cfg_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [1:0]        wr_data;
	} qmem_req_t;

	typedef struct packed {
		logic [8:0] car_height;
		logic       going_down;
		logic [1:0] at_floor;
		logic [2:0] riders;
		logic       request_dropped;
	} result_t;

	function automatic logic [1:0] floor_of(input logic [8:0] h, input logic [8:0] f1,
			input logic [8:0] f2);
		logic [1:0] f;
		if (h == 9'd0) begin
			f = 2'd0;
		end else if (h < f1) begin
			f = FLOOR_BETWEEN;
		end else if (h == f1) begin
			f = 2'd1;
		end else if (h == f2) begin
			f = 2'd2;
		end else begin
			f = FLOOR_BETWEEN;
		end
		return f;
	endfunction

endpackage

`default_nettype wire

/* design/elc_qmem.sv */
// Waiting-passenger queue memory: one entry per queued destination, three floor queues.
// One write port, one read port with registered data. Depends on elc_pkg.
`default_nettype none

module elc_qmem (
	input  wire logic                clk,
	input  wire elc_pkg::qmem_req_t  req,
	output logic [1:0]               rd_data_q
);

	logic [1:0] mem_q [elc_pkg::MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

/* design/elc_ctrl.sv */
// Elevator sequencer: car state, cabin list, queue lengths, idle timer, and the
// read-modify-write passes over the queue memory. Depends on elc_pkg.
`default_nettype none

module elc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               func,
	input  wire logic [1:0]         from_floor,
	input  wire logic [1:0]         to_floor,
	input  wire elc_pkg::cfg_t      cfg,
	input  wire logic [1:0]         rd_data,
	output elc_pkg::qmem_req_t      mem_req,
	output logic                    busy,
	output logic                    done,
	output elc_pkg::result_t        res
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_TICK   = 3'd1;
	localparam logic [2:0] ST_CABIN  = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_PACK   = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	localparam int LW = elc_pkg::LEN_W;
	localparam int CW = elc_pkg::CLEN_W;
	localparam int QW = elc_pkg::QIDX_W;
	localparam int CI = elc_pkg::CIDX_W;

	logic [2:0]       state_q, state_d;
	logic             busy_q, busy_d;
	logic             done_q, done_d;
	elc_pkg::result_t res_q, res_d;
	logic [8:0]       pos_q, pos_d;
	logic             dir_q, dir_d;
	logic             home_q, home_d;
	logic             armed_q, armed_d;
	logic [15:0]      icnt_q, icnt_d;
	logic [LW-1:0]    wlen_q [elc_pkg::NUM_FLOORS];
	logic [LW-1:0]    wlen_d [elc_pkg::NUM_FLOORS];
	logic [1:0]       cab_q [elc_pkg::MAX_RIDERS];
	logic [1:0]       cab_d [elc_pkg::MAX_RIDERS];
	logic [CW-1:0]    clen_q, clen_d;
	logic [CW-1:0]    ci_q, ci_d;
	logic [CW-1:0]    ck_q, ck_d;
	logic [1:0]       sf_q, sf_d;
	logic [LW-1:0]    cnt_q, cnt_d;
	logic [LW-1:0]    k_q, k_d;
	logic [elc_pkg::QUEUE_DEPTH-1:0] mask_q, mask_d;
	logic             drop_q, drop_d;
	logic             rv_s1, rv_d;
	logic [QW-1:0]    ridx_s1, ridx_d;

	logic [LW-1:0]    len_from, len_sf;
	logic             req_ok, any_wait, ahead, way, board, keep, up;
	logic [1:0]       cur_floor, cval;
	logic [15:0]      icnt_inc;
	logic [CW-1:0]    cap;

	assign busy    = busy_q;
	assign done    = done_q;
	assign res     = res_q;
	assign up      = ~dir_q;
	assign cur_floor = elc_pkg::floor_of(pos_q, cfg.floor1_height, cfg.floor2_height);
	assign icnt_inc  = (icnt_q != 16'hFFFF) ? icnt_q + 16'd1 : icnt_q;
	assign any_wait  = (wlen_q[0] != '0) || (wlen_q[1] != '0) || (wlen_q[2] != '0);
	assign cap = (32'(cfg.cabin_capacity) < 32'(elc_pkg::MAX_RIDERS)) ?
		CW'(cfg.cabin_capacity) : CW'(elc_pkg::MAX_RIDERS);
	assign way   = up ? (rd_data > sf_q) : (rd_data < sf_q);
	assign board = rv_s1 && way && (clen_q < cap);
	assign keep  = rv_s1 && !mask_q[ridx_s1];
	assign req_ok = (from_floor != elc_pkg::FLOOR_BETWEEN) &&
		(to_floor != elc_pkg::FLOOR_BETWEEN) && (from_floor != to_floor) &&
		(len_from < LW'(elc_pkg::QUEUE_DEPTH));

	always_comb begin
		len_from = '0;
		len_sf   = '0;
		for (int i = 0; i < elc_pkg::NUM_FLOORS; i++) begin
			if (from_floor == 2'(i)) len_from = wlen_q[i];
			if (sf_q == 2'(i)) len_sf = wlen_q[i];
		end
	end

	always_comb begin
		ahead = 1'b0;
		for (int i = 0; i < elc_pkg::MAX_RIDERS; i++) begin
			if ((CW'(i) < clen_q) && (up ? (cab_q[i] > sf_q) : (cab_q[i] < sf_q))) begin
				ahead = 1'b1;
			end
		end
		for (int i = 0; i < elc_pkg::NUM_FLOORS; i++) begin
			if ((up ? (2'(i) > sf_q) : (2'(i) < sf_q)) && (wlen_q[i] != '0)) begin
				ahead = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		busy_d  = busy_q;
		done_d  = 1'b0;
		res_d   = res_q;
		pos_d   = pos_q;
		dir_d   = dir_q;
		home_d  = home_q;
		armed_d = armed_q;
		icnt_d  = icnt_q;
		wlen_d  = wlen_q;
		cab_d   = cab_q;
		clen_d  = clen_q;
		ci_d    = ci_q;
		ck_d    = ck_q;
		sf_d    = sf_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		mask_d  = mask_q;
		drop_d  = drop_q;
		rv_d    = 1'b0;
		ridx_d  = ridx_s1;
		cval    = '0;
		mem_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					busy_d = 1'b1;
					if (func == elc_pkg::FUNC_REQUEST) begin
						icnt_d = '0;
						drop_d = ~req_ok;
						if (req_ok) begin
							mem_req.wr_en   = 1'b1;
							mem_req.wr_addr = {from_floor, QW'(len_from)};
							mem_req.wr_data = to_floor;
							for (int i = 0; i < elc_pkg::NUM_FLOORS; i++) begin
								if (from_floor == 2'(i)) wlen_d[i] = len_from + LW'(1);
							end
						end
						state_d = ST_FIN;
					end else begin
						drop_d  = 1'b0;
						state_d = ST_TICK;
					end
				end
			end
			ST_TICK: begin
				if (!any_wait && clen_q == '0 && !home_q) begin
					if (!armed_q) begin
						icnt_d  = '0;
						armed_d = 1'b1;
					end else begin
						icnt_d = icnt_inc;
						if (icnt_inc >= cfg.idle_ticks) begin
							dir_d   = 1'b1;
							home_d  = 1'b1;
							armed_d = 1'b0;
						end
					end
					state_d = ST_FIN;
				end else begin
					armed_d = 1'b0;
					if (cur_floor == 2'd0) home_d = 1'b0;
					if (cur_floor == elc_pkg::FLOOR_BETWEEN) begin
						pos_d   = dir_q ? pos_q - 9'd1 : pos_q + 9'd1;
						state_d = ST_FIN;
					end else begin
						sf_d    = cur_floor;
						ci_d    = '0;
						ck_d    = '0;
						state_d = ST_CABIN;
					end
				end
			end
			ST_CABIN: begin
				// unload riders bound for this floor, keep the rest in order
				if (ci_q < clen_q) begin
					cval = cab_q[ci_q[CI-1:0]];
					if (cval != sf_q) begin
						cab_d[ck_q[CI-1:0]] = cval;
						ck_d = ck_q + CW'(1);
					end
					ci_d = ci_q + CW'(1);
				end else begin
					clen_d  = ck_q;
					cnt_d   = len_sf;
					mask_d  = '0;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// newest to oldest; boarded entries marked for the pack pass
				if (cnt_q != '0) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = {sf_q, QW'(cnt_q - LW'(1))};
					rv_d   = 1'b1;
					ridx_d = QW'(cnt_q - LW'(1));
					cnt_d  = cnt_q - LW'(1);
				end
				if (board) begin
					cab_d[clen_q[CI-1:0]] = rd_data;
					clen_d = clen_q + CW'(1);
					mask_d[ridx_s1] = 1'b1;
				end
				if (cnt_q == '0) begin
					if (mask_d != '0) begin
						cnt_d   = '0;
						k_d     = '0;
						state_d = ST_PACK;
					end else begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_PACK: begin
				// oldest to newest; write slot never passes the read slot
				if (cnt_q < len_sf) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = {sf_q, cnt_q[QW-1:0]};
					rv_d   = 1'b1;
					ridx_d = cnt_q[QW-1:0];
					cnt_d  = cnt_q + LW'(1);
				end
				if (keep) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = {sf_q, k_q[QW-1:0]};
					mem_req.wr_data = rd_data;
					k_d = k_q + LW'(1);
				end
				if (cnt_q == len_sf) begin
					for (int i = 0; i < elc_pkg::NUM_FLOORS; i++) begin
						if (sf_q == 2'(i)) wlen_d[i] = k_d;
					end
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!dir_q) begin
					if (!ahead) dir_d = 1'b1;
					else pos_d = pos_q + 9'd1;
				end else begin
					if (!ahead && !home_q) dir_d = 1'b0;
					else pos_d = pos_q - 9'd1;
				end
				state_d = ST_FIN;
			end
			ST_FIN: begin
				res_d.car_height      = pos_q;
				res_d.going_down      = dir_q;
				res_d.at_floor        = cur_floor;
				res_d.riders          = 3'(clen_q);
				res_d.request_dropped = drop_q;
				done_d  = 1'b1;
				busy_d  = 1'b0;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			pos_q   <= '0;
			dir_q   <= 1'b0;
			home_q  <= 1'b0;
			armed_q <= 1'b0;
			icnt_q  <= '0;
			clen_q  <= '0;
			rv_s1   <= 1'b0;
			for (int i = 0; i < elc_pkg::NUM_FLOORS; i++) begin
				wlen_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			busy_q  <= busy_d;
			done_q  <= done_d;
			pos_q   <= pos_d;
			dir_q   <= dir_d;
			home_q  <= home_d;
			armed_q <= armed_d;
			icnt_q  <= icnt_d;
			clen_q  <= clen_d;
			rv_s1   <= rv_d;
			wlen_q  <= wlen_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q   <= res_d;
		cab_q   <= cab_d;
		ci_q    <= ci_d;
		ck_q    <= ck_d;
		sf_q    <= sf_d;
		cnt_q   <= cnt_d;
		k_q     <= k_d;
		mask_q  <= mask_d;
		drop_q  <= drop_d;
		ridx_s1 <= ridx_d;
	end

endmodule

`default_nettype wire

/* design/three_floor_elevator_controller_unit.sv */
// Top level of the three-floor elevator controller: configuration registers,
// sequencer and queue memory. Depends on elc_pkg, elc_qmem, elc_ctrl.
//
// channel   handshake                 word
// -------   ------------------------  ---------------------------------------------
// command   start / busy              func, from_floor, to_floor
// result    done (one-cycle strobe)   car_height, going_down, at_floor, riders,
//                                     request_dropped
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A request goes from acceptance straight to the result state; a tick between floors
// moves the car one step and finishes. A tick at a floor unloads the cabin list, scans
// that floor's queue and, when anyone boards, packs it, then decides the direction;
// these passes run serially over the queue memory's single read port.
// Reset clears car, timer, cabin count and queue lengths; no clearing pass is needed.
// Results cannot be stalled; the next command is taken in the cycle done is high.
`default_nettype none

module three_floor_elevator_controller_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [1:0]  from_floor,
	input  wire logic [1:0]  to_floor,
	output logic             done,
	output logic [8:0]       car_height,
	output logic             going_down,
	output logic [1:0]       at_floor,
	output logic [2:0]       riders,
	output logic             request_dropped,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	elc_pkg::cfg_t      cfg_q;
	elc_pkg::qmem_req_t mem_req;
	elc_pkg::result_t   res;
	logic [1:0]         rd_data;

	assign cfg_ready = ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_ticks     <= elc_pkg::RST_IDLE_TICKS;
			cfg_q.cabin_capacity <= elc_pkg::RST_CAPACITY;
			cfg_q.floor1_height  <= elc_pkg::RST_FLOOR1;
			cfg_q.floor2_height  <= elc_pkg::RST_FLOOR2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				elc_pkg::REG_IDLE_TICKS: cfg_q.idle_ticks     <= cfg_data;
				elc_pkg::REG_CAPACITY:   cfg_q.cabin_capacity <= cfg_data[2:0];
				elc_pkg::REG_FLOOR1:     cfg_q.floor1_height  <= cfg_data[8:0];
				elc_pkg::REG_FLOOR2:     cfg_q.floor2_height  <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	elc_qmem u_qmem (
		.clk       (clk),
		.req       (mem_req),
		.rd_data_q (rd_data)
	);

	elc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.from_floor (from_floor),
		.to_floor   (to_floor),
		.cfg        (cfg_q),
		.rd_data    (rd_data),
		.mem_req    (mem_req),
		.busy       (busy),
		.done       (done),
		.res        (res)
	);

	assign car_height      = res.car_height;
	assign going_down      = res.going_down;
	assign at_floor        = res.at_floor;
	assign riders          = res.riders;
	assign request_dropped = res.request_dropped;

endmodule

`default_nettype wire

/* design/elc_checker.sv */
// Port-level checks for the elevator controller, attached by bind.
// Depends on elc_pkg and three_floor_elevator_controller_unit.
`default_nettype none

module elc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [8:0] car_height,
	input wire logic [1:0] at_floor,
	input wire logic [2:0] riders
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command accepted without going busy");

	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result word");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result word outside a command");

	a_ground_height: assert property (@(posedge clk) disable iff (!arst_n)
		done && at_floor == 2'd0 |-> car_height == 9'd0)
		else $error("ground floor reported away from height zero");

	a_riders_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> riders <= 3'(elc_pkg::MAX_RIDERS))
		else $error("rider count above cabin limit");

endmodule

bind three_floor_elevator_controller_unit elc_checker u_elc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.car_height (car_height),
	.at_floor   (at_floor),
	.riders     (riders)
);

`default_nettype wire

/* bench/elevator_status_checker.sv */
// Checker for the three-floor elevator controller: watches the command, config and
// status channels, keeps its own model of car, queues and cabin, and compares each word.
// Depends on elc_pkg.
`timescale 1ns / 100ps

module elevator_status_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        func,
	input  logic [1:0]  from_floor,
	input  logic [1:0]  to_floor,
	input  logic        done,
	input  logic [8:0]  car_height,
	input  logic        going_down,
	input  logic [1:0]  at_floor,
	input  logic [2:0]  riders,
	input  logic        request_dropped,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          pending
);

	logic [15:0] idle_limit;
	logic [2:0]  capacity;
	logic [8:0]  f1_height;
	logic [8:0]  f2_height;

	logic [8:0]  car_pos;
	logic        dir_down;
	logic        heading_home;
	logic        idle_armed;
	logic [15:0] idle_cnt;
	logic [1:0]  waiting [3][elc_pkg::QUEUE_DEPTH];
	int          wait_len [3];
	logic [1:0]  cabin [elc_pkg::MAX_RIDERS];
	int          cabin_len;

	elc_pkg::result_t expected_status [$];
	int               errors;

	function automatic logic [1:0] level_at(input logic [8:0] h);
		if (h == 9'd0)
			return 2'd0;
		if (h < f1_height)
			return elc_pkg::FLOOR_BETWEEN;
		if (h == f1_height)
			return 2'd1;
		if (h == f2_height)
			return 2'd2;
		return elc_pkg::FLOOR_BETWEEN;
	endfunction

	function automatic logic work_ahead(input logic [1:0] fl, input logic up);
		for (int i = 0; i < cabin_len; i++) begin
			if (up ? (cabin[i] > fl) : (cabin[i] < fl))
				return 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			if ((up ? (i > int'(fl)) : (i < int'(fl))) && wait_len[i] != 0)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic serve_stop(input logic [1:0] fl, input logic up);
		int k;
		int cap;
		int idx;
		logic [1:0] d;
		logic way;
		k = 0;
		for (int i = 0; i < cabin_len; i++) begin
			if (cabin[i] != fl) begin
				cabin[k] = cabin[i];
				k++;
			end
		end
		cabin_len = k;
		cap = (int'(capacity) < elc_pkg::MAX_RIDERS) ? int'(capacity) : elc_pkg::MAX_RIDERS;
		for (int i = wait_len[fl]; i > 0; i--) begin
			idx = i - 1;
			d = waiting[fl][idx];
			way = up ? (d > fl) : (d < fl);
			if (way && cabin_len < cap) begin
				cabin[cabin_len] = d;
				cabin_len++;
				for (int j = idx; j < wait_len[fl] - 1; j++)
					waiting[fl][j] = waiting[fl][j + 1];
				wait_len[fl]--;
			end
		end
	endtask

	task automatic take_tick();
		logic [1:0] fl;
		logic any_wait;
		any_wait = (wait_len[0] != 0) || (wait_len[1] != 0) || (wait_len[2] != 0);
		if (!any_wait && cabin_len == 0 && !heading_home) begin
			if (!idle_armed) begin
				idle_cnt = '0;
				idle_armed = 1'b1;
			end else begin
				if (idle_cnt != 16'hFFFF)
					idle_cnt++;
				if (idle_cnt >= idle_limit) begin
					dir_down = 1'b1;
					heading_home = 1'b1;
					idle_armed = 1'b0;
				end
			end
			return;
		end
		idle_armed = 1'b0;
		fl = level_at(car_pos);
		if (fl == 2'd0)
			heading_home = 1'b0;
		if (!dir_down) begin
			if (fl == elc_pkg::FLOOR_BETWEEN) begin
				car_pos++;
			end else begin
				serve_stop(fl, 1'b1);
				if (!work_ahead(fl, 1'b1))
					dir_down = 1'b1;
				else
					car_pos++;
			end
		end else begin
			if (fl == elc_pkg::FLOOR_BETWEEN) begin
				car_pos--;
			end else begin
				serve_stop(fl, 1'b0);
				if (!work_ahead(fl, 1'b0) && !heading_home)
					dir_down = 1'b0;
				else
					car_pos--;
			end
		end
	endtask

	task automatic step_car(input logic fn, input logic [1:0] src, input logic [1:0] dst,
			output elc_pkg::result_t r);
		logic dropped;
		dropped = 1'b0;
		if (fn == elc_pkg::FUNC_REQUEST) begin
			idle_cnt = '0;
			if (src > 2'd2 || dst > 2'd2 || src == dst ||
					wait_len[src] >= elc_pkg::QUEUE_DEPTH) begin
				dropped = 1'b1;
			end else begin
				waiting[src][wait_len[src]] = dst;
				wait_len[src]++;
			end
		end else begin
			take_tick();
		end
		r.car_height = car_pos;
		r.going_down = dir_down;
		r.at_floor = level_at(car_pos);
		r.riders = cabin_len[2:0];
		r.request_dropped = dropped;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		elc_pkg::result_t exp_r;
		if (!arst_n) begin
			idle_limit = elc_pkg::RST_IDLE_TICKS;
			capacity = elc_pkg::RST_CAPACITY;
			f1_height = elc_pkg::RST_FLOOR1;
			f2_height = elc_pkg::RST_FLOOR2;
			car_pos = '0;
			dir_down = 1'b0;
			heading_home = 1'b0;
			idle_armed = 1'b0;
			idle_cnt = '0;
			wait_len = '{0, 0, 0};
			cabin_len = 0;
			expected_status.delete();
			errors = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					elc_pkg::REG_IDLE_TICKS: idle_limit = cfg_data;
					elc_pkg::REG_CAPACITY:   capacity = cfg_data[2:0];
					elc_pkg::REG_FLOOR1:     f1_height = cfg_data[8:0];
					elc_pkg::REG_FLOOR2:     f2_height = cfg_data[8:0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_status.size() == 0) begin
					$error("status word with none expected");
					errors++;
				end else begin
					exp_r = expected_status.pop_front();
					check_field("car_height", int'(exp_r.car_height), int'(car_height));
					check_field("going_down", int'(exp_r.going_down), int'(going_down));
					check_field("at_floor", int'(exp_r.at_floor), int'(at_floor));
					check_field("riders", int'(exp_r.riders), int'(riders));
					check_field("request_dropped", int'(exp_r.request_dropped),
						int'(request_dropped));
				end
			end
			if (start && !busy) begin
				step_car(func, from_floor, to_floor, exp_r);
				expected_status.insert(expected_status.size(), exp_r);
			end
			mismatches <= errors;
			pending <= expected_status.size();
		end
	end

endmodule

/* bench/three_floor_elevator_controller_unit_test.sv */
// Testbench top for the three-floor elevator controller: clock, reset, command and
// config stimulus, timeout and verdict. Depends on elc_pkg and elevator_status_checker.
`timescale 1ns / 100ps

module three_floor_elevator_controller_unit_test;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASES       = 12;
	localparam int PHASE_WORDS  = 140;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [1:0]  from_floor;
	logic [1:0]  to_floor;
	logic        done;
	logic [8:0]  car_height;
	logic        going_down;
	logic [1:0]  at_floor;
	logic [2:0]  riders;
	logic        request_dropped;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int mismatches;
	int pending;
	int cycles = 0;
	bit steady;

	three_floor_elevator_controller_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.from_floor(from_floor),
		.to_floor(to_floor),
		.done(done),
		.car_height(car_height),
		.going_down(going_down),
		.at_floor(at_floor),
		.riders(riders),
		.request_dropped(request_dropped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	elevator_status_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.from_floor(from_floor),
		.to_floor(to_floor),
		.done(done),
		.car_height(car_height),
		.going_down(going_down),
		.at_floor(at_floor),
		.riders(riders),
		.request_dropped(request_dropped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("three_floor_elevator_controller_unit_test failed");
			$finish;
		end
	end

	task automatic send_word(input logic fn, input logic [1:0] src, input logic [1:0] dst);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= fn;
		from_floor <= src;
		to_floor <= dst;
		do @(posedge clk); while (busy);
	endtask

	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_settings(input logic [15:0] idle, input logic [2:0] cap,
			input logic [8:0] f1, input logic [8:0] f2);
		logic [15:0] junk;
		quiesce();
		junk = 16'($urandom);
		write_reg(elc_pkg::REG_IDLE_TICKS, idle);
		write_reg(elc_pkg::REG_CAPACITY, {junk[15:3], cap});
		write_reg(elc_pkg::REG_FLOOR1, {junk[15:9], f1});
		write_reg(elc_pkg::REG_FLOOR2, {~junk[15:9], f2});
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int budget);
		int sent;
		int r;
		int src;
		int dst;
		int n;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				// fill one queue past its depth
				src = $urandom_range(0, 2);
				repeat (elc_pkg::QUEUE_DEPTH + 1) begin
					dst = (src + $urandom_range(1, 2)) % 3;
					send_word(elc_pkg::FUNC_REQUEST, 2'(src), 2'(dst));
				end
				sent += elc_pkg::QUEUE_DEPTH + 1;
			end else if (r < 33) begin
				if ($urandom_range(0, 6) == 0) begin
					src = $urandom_range(0, 3);
					dst = $urandom_range(0, 3);
				end else begin
					src = $urandom_range(0, 2);
					dst = (src + $urandom_range(1, 2)) % 3;
				end
				send_word(elc_pkg::FUNC_REQUEST, 2'(src), 2'(dst));
				sent++;
			end else begin
				n = $urandom_range(1, 12);
				repeat (n)
					send_word(elc_pkg::FUNC_TICK, 2'($urandom_range(0, 3)),
						2'($urandom_range(0, 3)));
				sent += n;
			end
		end
	endtask

	initial begin
		logic [8:0] f1;
		logic [8:0] f2;
		arst_n = 1'b0;
		start = 1'b0;
		func = elc_pkg::FUNC_TICK;
		from_floor = 2'd0;
		to_floor = 2'd0;
		cfg_valid = 1'b0;
		cfg_index = elc_pkg::REG_IDLE_TICKS;
		cfg_data = '0;
		steady = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_settings(16'd2, 3'd1, 9'd2, 9'd4);
		send_word(elc_pkg::FUNC_REQUEST, 2'd0, 2'd0);
		send_word(elc_pkg::FUNC_REQUEST, 2'd3, 2'd1);
		send_word(elc_pkg::FUNC_REQUEST, 2'd1, 2'd3);
		send_word(elc_pkg::FUNC_REQUEST, 2'd3, 2'd3);
		send_word(elc_pkg::FUNC_REQUEST, 2'd2, 2'd2);
		send_word(elc_pkg::FUNC_REQUEST, 2'd0, 2'd2);
		send_word(elc_pkg::FUNC_REQUEST, 2'd0, 2'd1);
		send_word(elc_pkg::FUNC_REQUEST, 2'd1, 2'd2);
		send_word(elc_pkg::FUNC_REQUEST, 2'd2, 2'd0);
		send_word(elc_pkg::FUNC_REQUEST, 2'd2, 2'd1);
		send_word(elc_pkg::FUNC_REQUEST, 2'd1, 2'd0);
		repeat (14)
			send_word(elc_pkg::FUNC_TICK, 2'd3, 2'd3);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: write_settings(16'd0, 3'd0, 9'd1, 9'd2);
				2: write_settings(16'hFFFF, 3'd7, 9'd510, 9'd511);
				3: write_settings(elc_pkg::RST_IDLE_TICKS, elc_pkg::RST_CAPACITY,
					elc_pkg::RST_FLOOR1, elc_pkg::RST_FLOOR2);
				4: write_settings(16'd1, 3'd1, 9'd0, 9'd0);
				default: begin
					f1 = 9'($urandom_range(1, 6));
					if ($urandom_range(0, 4) == 0)
						f2 = 9'($urandom_range(0, 511));
					else
						f2 = f1 + 9'($urandom_range(1, 6));
					write_settings(16'($urandom_range(0, 6)), 3'($urandom_range(0, 7)),
						f1, f2);
				end
			endcase
			steady = ($urandom_range(0, 3) == 0);
			run_phase(PHASE_WORDS);
		end

		quiesce();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("three_floor_elevator_controller_unit_test passed");
		else
			$display("three_floor_elevator_controller_unit_test failed");
		$finish;
	end

endmodule

/* filelist.f */
design/elc_pkg.sv
design/elc_qmem.sv
design/elc_ctrl.sv
design/three_floor_elevator_controller_unit.sv
design/elc_checker.sv
bench/elevator_status_checker.sv
bench/three_floor_elevator_controller_unit_test.sv
